/* rtl/core/owm_pkg.sv */
// Shared types, codes and helpers for the one-wire bus master.
// Standalone package; every other file in rtl/core except owm_ifs refers to it by scoped names.
`timescale 1ns / 1ps

package owm_pkg;

  // Widths of the configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // Fixed high-phase lengths of the two write slot kinds.
  localparam logic [9:0] WrOneHigh  = 10'd65;
  localparam logic [9:0] WrZeroHigh = 10'd2;

  // Bus drive codes.
  localparam logic [1:0] DrvRelease = 2'd0;
  localparam logic [1:0] DrvLow     = 2'd1;
  localparam logic [1:0] DrvHigh    = 2'd2;

  // Command codes.
  localparam logic [1:0] ModeReset = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;
  localparam logic [1:0] ModeNone  = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_LOW  = 3'd0,
    REG_RESET_HIGH = 3'd1,
    REG_PRES_WAIT  = 3'd2,
    REG_PRES_LOW   = 3'd3,
    REG_WR_ONE     = 3'd4,
    REG_WR_ZERO    = 3'd5,
    REG_RD_LOW     = 3'd6,
    REG_RD_TAIL    = 3'd7
  } owm_reg_e;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_RST_LOW   = 10'b00_0000_0010,
    PH_RST_HIGH  = 10'b00_0000_0100,
    PH_PRES_WAIT = 10'b00_0000_1000,
    PH_PRES_LOW  = 10'b00_0001_0000,
    PH_WR_LOW    = 10'b00_0010_0000,
    PH_WR_HIGH   = 10'b00_0100_0000,
    PH_RD_LOW    = 10'b00_1000_0000,
    PH_RD_SAMPLE = 10'b01_0000_0000,
    PH_RD_TAIL   = 10'b10_0000_0000
  } owm_phase_e;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] reset_high_time;
    logic [7:0] presence_wait_max;
    logic [7:0] presence_low_max;
    logic [7:0] write_one_low;
    logic [7:0] write_zero_low;
    logic [7:0] read_low;
    logic [7:0] read_tail;
  } owm_cfg_t;

  typedef struct packed {
    owm_phase_e phase;
    logic [9:0] tick_count;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] received_byte;
    logic       fail_flag;
  } owm_state_t;

  typedef struct packed {
    logic       line_level;
    logic       start_req;
    logic [1:0] mode;
    logic [7:0] tx_byte;
  } owm_item_t;

  typedef struct packed {
    logic [1:0] bus_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       presence_fail;
  } owm_res_t;

  // True on the last tick of a segment of len ticks; a length of zero acts as one.
  function automatic logic seg_last(input logic [9:0] tick, input logic [9:0] len);
    logic [10:0] nxt;
    nxt = {1'b0, tick} + 11'd1;
    return nxt >= {1'b0, len};
  endfunction

endpackage

/* rtl/core/owm_ifs.sv */
// Valid/ready channel interfaces for the one-wire bus master.
// Depends on nothing; payload fields are plain vectors.
`timescale 1ns / 1ps

interface owm_req_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic       start_req;
  logic [1:0] mode;
  logic [7:0] tx_byte;

  modport source (output valid, line_level, start_req, mode, tx_byte, input ready);
  modport sink   (input valid, line_level, start_req, mode, tx_byte, output ready);
endinterface

interface owm_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] bus_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       presence_fail;

  modport source (output valid, bus_drive, busy_res, done_res, rx_byte, presence_fail,
                  input ready);
  modport sink   (input valid, bus_drive, busy_res, done_res, rx_byte, presence_fail,
                  output ready);
endinterface

/* rtl/core/owm_cfg.sv */
// Timing register file of the one-wire bus master.
// Depends on owm_pkg for the register index codes and the register struct.
`timescale 1ns / 1ps

module owm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [owm_pkg::CfgDataW-1:0] cfg_wdata_i,
  output owm_pkg::owm_cfg_t            cfg_o
);

  owm_pkg::owm_cfg_t cfg_q, cfg_d;
  owm_pkg::owm_reg_e reg_idx;

  assign reg_idx = owm_pkg::owm_reg_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx)
        owm_pkg::REG_RESET_LOW:  cfg_d.reset_low_time    = cfg_wdata_i;
        owm_pkg::REG_RESET_HIGH: cfg_d.reset_high_time   = cfg_wdata_i[7:0];
        owm_pkg::REG_PRES_WAIT:  cfg_d.presence_wait_max = cfg_wdata_i[7:0];
        owm_pkg::REG_PRES_LOW:   cfg_d.presence_low_max  = cfg_wdata_i[7:0];
        owm_pkg::REG_WR_ONE:     cfg_d.write_one_low     = cfg_wdata_i[7:0];
        owm_pkg::REG_WR_ZERO:    cfg_d.write_zero_low    = cfg_wdata_i[7:0];
        owm_pkg::REG_RD_LOW:     cfg_d.read_low          = cfg_wdata_i[7:0];
        owm_pkg::REG_RD_TAIL:    cfg_d.read_tail         = cfg_wdata_i[7:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time    <= 10'd750;
      cfg_q.reset_high_time   <= 8'd15;
      cfg_q.presence_wait_max <= 8'd100;
      cfg_q.presence_low_max  <= 8'd240;
      cfg_q.write_one_low     <= 8'd5;
      cfg_q.write_zero_low    <= 8'd70;
      cfg_q.read_low          <= 8'd10;
      cfg_q.read_tail         <= 8'd45;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/owm_step.sv */
// Per-tick next-state and result logic of the one-wire bus master.
// Depends on owm_pkg for the phase codes, structs and the segment helper.
`timescale 1ns / 1ps

module owm_step (
  input  owm_pkg::owm_state_t state_i,
  input  owm_pkg::owm_cfg_t   cfg_i,
  input  owm_pkg::owm_item_t  item_i,
  output owm_pkg::owm_state_t state_o,
  output owm_pkg::owm_res_t   res_o
);

  owm_pkg::owm_state_t s, n;
  logic [9:0] tick_inc;
  logic [9:0] wr_low_len;
  logic [9:0] wr_high_len;
  logic [1:0] drive;
  logic       busy;
  logic       done;

  always_comb begin
    // A start request is taken only while idle and only with a known command.
    s = state_i;
    if (s.phase == owm_pkg::PH_IDLE && item_i.start_req && item_i.mode != owm_pkg::ModeNone)
    begin
      s.bit_index  = 3'd0;
      s.tick_count = 10'd0;
      s.shift_byte = (item_i.mode == owm_pkg::ModeWrite) ? item_i.tx_byte : 8'd0;
      unique case (item_i.mode)
        owm_pkg::ModeReset: s.phase = owm_pkg::PH_RST_LOW;
        owm_pkg::ModeWrite: s.phase = owm_pkg::PH_WR_LOW;
        owm_pkg::ModeRead:  s.phase = owm_pkg::PH_RD_LOW;
        default:            s.phase = owm_pkg::PH_IDLE;
      endcase
    end

    n           = s;
    drive       = owm_pkg::DrvRelease;
    busy        = (s.phase != owm_pkg::PH_IDLE);
    done        = 1'b0;
    tick_inc    = s.tick_count + 10'd1;
    wr_low_len  = s.shift_byte[0] ? {2'b00, cfg_i.write_one_low}
                                  : {2'b00, cfg_i.write_zero_low};
    wr_high_len = s.shift_byte[0] ? owm_pkg::WrOneHigh : owm_pkg::WrZeroHigh;

    unique case (s.phase)
      owm_pkg::PH_IDLE: begin
        n.tick_count = s.tick_count;
      end
      owm_pkg::PH_RST_LOW: begin
        drive = owm_pkg::DrvLow;
        if (owm_pkg::seg_last(s.tick_count, cfg_i.reset_low_time)) begin
          n.tick_count = 10'd0;
          n.phase      = owm_pkg::PH_RST_HIGH;
        end else begin
          n.tick_count = tick_inc;
        end
      end
      owm_pkg::PH_RST_HIGH: begin
        drive = owm_pkg::DrvHigh;
        if (owm_pkg::seg_last(s.tick_count, {2'b00, cfg_i.reset_high_time})) begin
          n.tick_count = 10'd0;
          n.phase      = owm_pkg::PH_PRES_WAIT;
        end else begin
          n.tick_count = tick_inc;
        end
      end
      owm_pkg::PH_PRES_WAIT: begin
        if (item_i.line_level) begin
          if (owm_pkg::seg_last(s.tick_count, {2'b00, cfg_i.presence_wait_max})) begin
            n.fail_flag  = 1'b1;
            n.tick_count = 10'd0;
            n.phase      = owm_pkg::PH_IDLE;
            done         = 1'b1;
          end else begin
            n.tick_count = tick_inc;
          end
        end else if (owm_pkg::seg_last(10'd0, {2'b00, cfg_i.presence_low_max})) begin
          // The first low sample is already the pulse's first low tick.
          n.fail_flag  = 1'b1;
          n.tick_count = 10'd0;
          n.phase      = owm_pkg::PH_IDLE;
          done         = 1'b1;
        end else begin
          n.tick_count = 10'd1;
          n.phase      = owm_pkg::PH_PRES_LOW;
        end
      end
      owm_pkg::PH_PRES_LOW: begin
        if (item_i.line_level) begin
          n.fail_flag  = 1'b0;
          n.tick_count = 10'd0;
          n.phase      = owm_pkg::PH_IDLE;
          done         = 1'b1;
        end else if (owm_pkg::seg_last(s.tick_count, {2'b00, cfg_i.presence_low_max})) begin
          n.fail_flag  = 1'b1;
          n.tick_count = 10'd0;
          n.phase      = owm_pkg::PH_IDLE;
          done         = 1'b1;
        end else begin
          n.tick_count = tick_inc;
        end
      end
      owm_pkg::PH_WR_LOW: begin
        drive = owm_pkg::DrvLow;
        if (owm_pkg::seg_last(s.tick_count, wr_low_len)) begin
          n.tick_count = 10'd0;
          n.phase      = owm_pkg::PH_WR_HIGH;
        end else begin
          n.tick_count = tick_inc;
        end
      end
      owm_pkg::PH_WR_HIGH: begin
        drive = owm_pkg::DrvHigh;
        if (owm_pkg::seg_last(s.tick_count, wr_high_len)) begin
          n.shift_byte = {1'b0, s.shift_byte[7:1]};
          n.tick_count = 10'd0;
          if (s.bit_index == 3'd7) begin
            n.phase = owm_pkg::PH_IDLE;
            done    = 1'b1;
          end else begin
            n.bit_index = s.bit_index + 3'd1;
            n.phase     = owm_pkg::PH_WR_LOW;
          end
        end else begin
          n.tick_count = tick_inc;
        end
      end
      owm_pkg::PH_RD_LOW: begin
        drive = owm_pkg::DrvLow;
        if (owm_pkg::seg_last(s.tick_count, {2'b00, cfg_i.read_low})) begin
          n.tick_count = 10'd0;
          n.phase      = owm_pkg::PH_RD_SAMPLE;
        end else begin
          n.tick_count = tick_inc;
        end
      end
      owm_pkg::PH_RD_SAMPLE: begin
        n.shift_byte = s.shift_byte | (8'(item_i.line_level) << s.bit_index);
        n.tick_count = 10'd0;
        n.phase      = owm_pkg::PH_RD_TAIL;
      end
      owm_pkg::PH_RD_TAIL: begin
        if (owm_pkg::seg_last(s.tick_count, {2'b00, cfg_i.read_tail})) begin
          n.tick_count = 10'd0;
          if (s.bit_index == 3'd7) begin
            n.received_byte = s.shift_byte;
            n.phase         = owm_pkg::PH_IDLE;
            done            = 1'b1;
          end else begin
            n.bit_index = s.bit_index + 3'd1;
            n.phase     = owm_pkg::PH_RD_LOW;
          end
        end else begin
          n.tick_count = tick_inc;
        end
      end
      default: begin
        n.phase      = owm_pkg::PH_IDLE;
        n.tick_count = 10'd0;
        busy         = 1'b0;
      end
    endcase
  end

  assign state_o             = n;
  assign res_o.bus_drive     = drive;
  assign res_o.busy_res      = busy;
  assign res_o.done_res      = done;
  assign res_o.rx_byte       = n.received_byte;
  assign res_o.presence_fail = n.fail_flag;

endmodule

/* rtl/core/one_wire_master.sv */
// Latency: a result appears in the output register on the cycle after its tick is taken.
// Throughput: one tick transaction per clock; a new tick is taken whenever the output
// register is empty or is being emptied in the same cycle, so a stalled sink stalls input.
// The whole per-tick update is one pass of the step logic from the state register.
// Reset (rst_ni low, asynchronous) returns to idle with all timing registers at defaults.
`timescale 1ns / 1ps

// One-wire bus master top level: state and output registers around the step logic.
// Depends on owm_pkg, owm_ifs (channel interfaces), owm_cfg and owm_step.
module one_wire_master (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [owm_pkg::CfgDataW-1:0] cfg_wdata_i,
  owm_req_if.sink                      req_i,
  owm_res_if.source                    res_o
);

  owm_pkg::owm_cfg_t   cfg;
  owm_pkg::owm_item_t  item;
  owm_pkg::owm_state_t state_q, state_d;
  owm_pkg::owm_res_t   res_d, res_q;
  logic                out_valid_q;
  logic                in_accept;

  // The timing registers live in their own block; writes take effect immediately,
  // including inside a segment that is already running.
  owm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign item.line_level = req_i.line_level;
  assign item.start_req  = req_i.start_req;
  assign item.mode       = req_i.mode;
  assign item.tx_byte    = req_i.tx_byte;

  // All sequencing for one tick: command start, segment counting, bit shifting,
  // presence evaluation and the drive code for this tick.
  owm_step u_step (
    .state_i(state_q),
    .cfg_i  (cfg),
    .item_i (item),
    .state_o(state_d),
    .res_o  (res_d)
  );

  // The output register decouples the two sides: a new tick may enter while the
  // previous result is being taken by the sink in the same cycle.
  assign req_i.ready = !out_valid_q || res_o.ready;
  assign in_accept   = req_i.valid && req_i.ready;

  // The sequencer state advances only on a taken tick, so idle cycles on the
  // input side do not count as bus time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= owm_pkg::PH_IDLE;
      state_q.tick_count    <= 10'd0;
      state_q.bit_index     <= 3'd0;
      state_q.shift_byte    <= 8'd0;
      state_q.received_byte <= 8'd0;
      state_q.fail_flag     <= 1'b0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.bus_drive     = res_q.bus_drive;
  assign res_o.busy_res      = res_q.busy_res;
  assign res_o.done_res      = res_q.done_res;
  assign res_o.rx_byte       = res_q.rx_byte;
  assign res_o.presence_fail = res_q.presence_fail;

  // A completing tick always belongs to a command in progress.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> res_o.busy_res)
    else $error("done reported on a tick that was not busy");

  // An idle tick without a start request leaves the sequencer idle.
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && state_q.phase == owm_pkg::PH_IDLE && !req_i.start_req
    |=> state_q.phase == owm_pkg::PH_IDLE)
    else $error("sequencer left idle without a start request");

  // Bus timing advances only on taken ticks.
  a_state_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(state_q))
    else $error("sequencer state changed without a taken tick");

endmodule

/* tb/one_wire_master_tb.sv */
// Self-checking testbench for the one-wire bus master: drives microsecond tick
// transactions, predicts every bus result in a local cycle model and compares them.
// Depends on owm_pkg, the owm_req_if/owm_res_if interfaces and one_wire_master.
`timescale 1ns / 1ps

module one_wire_master_tb;

  // Far above the slowest legal run.
  localparam int unsigned RunLimit = 2_000_000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [owm_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [owm_pkg::CfgDataW-1:0] cfg_wdata_i;

  owm_req_if tick_ch ();
  owm_res_if bus_ch ();

  one_wire_master dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (tick_ch),
    .res_o       (bus_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cycle model of the bus master. It advances once per accepted tick
  // transaction, so its state always matches the block after that transaction.
  // ---------------------------------------------------------------------------
  owm_pkg::owm_cfg_t   timing;
  owm_pkg::owm_phase_e cur_phase;
  logic [9:0]          seg_tick;
  logic [2:0]          bit_pos;
  logic [7:0]          shift_reg;
  logic [7:0]          last_rx;
  logic                pres_fail;

  owm_pkg::owm_res_t bus_results_due[$];  // predicted results, oldest first
  int unsigned ticks_sent = 0;
  int unsigned cmds_done  = 0;
  int unsigned fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;

  // When set, the tick source or the result sink never inserts idle cycles.
  bit src_quiet = 1'b0;
  bit snk_quiet = 1'b0;

  function automatic void reset_model();
    timing = '{reset_low_time: 10'd750, reset_high_time: 8'd15, presence_wait_max: 8'd100,
               presence_low_max: 8'd240, write_one_low: 8'd5, write_zero_low: 8'd70,
               read_low: 8'd10, read_tail: 8'd45};
    cur_phase = owm_pkg::PH_IDLE;
    seg_tick  = '0;
    bit_pos   = '0;
    shift_reg = '0;
    last_rx   = '0;
    pres_fail = 1'b0;
  endfunction

  function automatic void enter(input owm_pkg::owm_phase_e nxt);
    cur_phase = nxt;
    seg_tick  = '0;
  endfunction

  // Counts one tick of a segment; true on its last tick. A length of zero
  // behaves like a length of one.
  function automatic bit seg_over(input logic [9:0] len);
    if ({1'b0, seg_tick} + 11'd1 >= {1'b0, len}) begin
      seg_tick = '0;
      return 1'b1;
    end
    seg_tick = seg_tick + 10'd1;
    return 1'b0;
  endfunction

  function automatic owm_pkg::owm_res_t predict_bus_tick(input owm_pkg::owm_item_t it);
    owm_pkg::owm_res_t r;
    logic              fin;
    r = '0;
    r.bus_drive = owm_pkg::DrvRelease;
    fin = 1'b0;

    // A command is taken only while idle and only with a defined mode; the
    // start tick already belongs to the first segment.
    if (cur_phase == owm_pkg::PH_IDLE && it.start_req && it.mode != owm_pkg::ModeNone) begin
      bit_pos   = '0;
      shift_reg = (it.mode == owm_pkg::ModeWrite) ? it.tx_byte : 8'h00;
      case (it.mode)
        owm_pkg::ModeReset: enter(owm_pkg::PH_RST_LOW);
        owm_pkg::ModeWrite: enter(owm_pkg::PH_WR_LOW);
        default:            enter(owm_pkg::PH_RD_LOW);
      endcase
    end
    r.busy_res = (cur_phase != owm_pkg::PH_IDLE);

    case (cur_phase)
      owm_pkg::PH_IDLE: ;
      owm_pkg::PH_RST_LOW: begin
        r.bus_drive = owm_pkg::DrvLow;
        if (seg_over(timing.reset_low_time)) enter(owm_pkg::PH_RST_HIGH);
      end
      owm_pkg::PH_RST_HIGH: begin
        r.bus_drive = owm_pkg::DrvHigh;
        if (seg_over({2'b00, timing.reset_high_time})) enter(owm_pkg::PH_PRES_WAIT);
      end
      owm_pkg::PH_PRES_WAIT, owm_pkg::PH_PRES_LOW: begin
        if (cur_phase == owm_pkg::PH_PRES_WAIT && it.line_level) begin
          // Still waiting for the slave to pull the line low.
          if (seg_over({2'b00, timing.presence_wait_max})) begin
            pres_fail = 1'b1;
            fin = 1'b1;
          end
        end else if (cur_phase == owm_pkg::PH_PRES_LOW && it.line_level) begin
          // The presence pulse ended in time.
          pres_fail = 1'b0;
          fin = 1'b1;
        end else begin
          // A low sample; the first one opens the pulse and counts as its first tick.
          if (cur_phase == owm_pkg::PH_PRES_WAIT) enter(owm_pkg::PH_PRES_LOW);
          if (seg_over({2'b00, timing.presence_low_max})) begin
            pres_fail = 1'b1;
            fin = 1'b1;
          end
        end
      end
      owm_pkg::PH_WR_LOW: begin
        r.bus_drive = owm_pkg::DrvLow;
        if (seg_over(shift_reg[0] ? {2'b00, timing.write_one_low}
                                  : {2'b00, timing.write_zero_low}))
          enter(owm_pkg::PH_WR_HIGH);
      end
      owm_pkg::PH_WR_HIGH: begin
        r.bus_drive = owm_pkg::DrvHigh;
        if (seg_over(shift_reg[0] ? owm_pkg::WrOneHigh : owm_pkg::WrZeroHigh)) begin
          shift_reg = shift_reg >> 1;
          if (bit_pos == 3'd7) begin
            fin = 1'b1;
          end else begin
            bit_pos = bit_pos + 3'd1;
            enter(owm_pkg::PH_WR_LOW);
          end
        end
      end
      owm_pkg::PH_RD_LOW: begin
        r.bus_drive = owm_pkg::DrvLow;
        if (seg_over({2'b00, timing.read_low})) enter(owm_pkg::PH_RD_SAMPLE);
      end
      owm_pkg::PH_RD_SAMPLE: begin
        shift_reg[bit_pos] = shift_reg[bit_pos] | it.line_level;
        enter(owm_pkg::PH_RD_TAIL);
      end
      owm_pkg::PH_RD_TAIL: begin
        if (seg_over({2'b00, timing.read_tail})) begin
          if (bit_pos == 3'd7) begin
            last_rx = shift_reg;
            fin = 1'b1;
          end else begin
            bit_pos = bit_pos + 3'd1;
            enter(owm_pkg::PH_RD_LOW);
          end
        end
      end
      default: begin
        enter(owm_pkg::PH_IDLE);
        r.busy_res = 1'b0;
      end
    endcase

    if (fin) begin
      enter(owm_pkg::PH_IDLE);
      r.done_res = 1'b1;
      cmds_done++;
    end
    r.rx_byte       = last_rx;
    r.presence_fail = pres_fail;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: a sink with random stalls and a checker that compares every
  // result transaction with the oldest prediction.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    bus_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = snk_quiet ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        bus_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      bus_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!bus_ch.valid);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    owm_pkg::owm_res_t want;
    if (rst_ni && bus_ch.valid && bus_ch.ready) begin
      if (bus_results_due.size() == 0) begin
        $error("bus result transaction with no tick waiting for it");
        fail_cnt++;
      end else begin
        want = bus_results_due.pop_front();
        check_field("bus_drive", 8'(want.bus_drive), 8'(bus_ch.bus_drive));
        check_field("busy_res", 8'(want.busy_res), 8'(bus_ch.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(bus_ch.done_res));
        check_field("rx_byte", want.rx_byte, bus_ch.rx_byte);
        check_field("presence_fail", 8'(want.presence_fail), 8'(bus_ch.presence_fail));
      end
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= RunLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tick source and configuration helpers.
  // ---------------------------------------------------------------------------

  // Sends one tick transaction after a random gap and predicts its result at
  // the edge where it is accepted. Valid stays high after acceptance so that a
  // back-to-back tick never lowers and raises it in the same time step.
  task automatic send_tick(input owm_pkg::owm_item_t it);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.line_level <= it.line_level;
    tick_ch.start_req  <= it.start_req;
    tick_ch.mode       <= it.mode;
    tick_ch.tx_byte    <= it.tx_byte;
    do @(posedge clk_i); while (!tick_ch.ready);
    bus_results_due.push_back(predict_bus_tick(it));
    ticks_sent++;
  endtask

  // Stops sending and waits until every predicted result has been taken. The
  // block then has nothing in flight, so a register write is safe.
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input owm_pkg::owm_reg_e idx, input logic [9:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      owm_pkg::REG_RESET_LOW:  timing.reset_low_time    = val;
      owm_pkg::REG_RESET_HIGH: timing.reset_high_time   = val[7:0];
      owm_pkg::REG_PRES_WAIT:  timing.presence_wait_max = val[7:0];
      owm_pkg::REG_PRES_LOW:   timing.presence_low_max  = val[7:0];
      owm_pkg::REG_WR_ONE:     timing.write_one_low     = val[7:0];
      owm_pkg::REG_WR_ZERO:    timing.write_zero_low    = val[7:0];
      owm_pkg::REG_RD_LOW:     timing.read_low          = val[7:0];
      default:                 timing.read_tail         = val[7:0];
    endcase
  endtask

  // Writes all eight timing registers; pad fills the unused upper data bits of
  // the 8-bit registers, which the block must ignore.
  task automatic program_timing(input owm_pkg::owm_cfg_t c, input logic [1:0] pad);
    write_reg(owm_pkg::REG_RESET_LOW, c.reset_low_time);
    write_reg(owm_pkg::REG_RESET_HIGH, {pad, c.reset_high_time});
    write_reg(owm_pkg::REG_PRES_WAIT, {pad, c.presence_wait_max});
    write_reg(owm_pkg::REG_PRES_LOW, {pad, c.presence_low_max});
    write_reg(owm_pkg::REG_WR_ONE, {pad, c.write_one_low});
    write_reg(owm_pkg::REG_WR_ZERO, {pad, c.write_zero_low});
    write_reg(owm_pkg::REG_RD_LOW, {pad, c.read_low});
    write_reg(owm_pkg::REG_RD_TAIL, {pad, c.read_tail});
    cfg_we_i <= 1'b0;
  endtask

  // Ticks with no command: either no request, or a request with the unused mode.
  task automatic idle_ticks(input int n);
    owm_pkg::owm_item_t it;
    repeat (n) begin
      it.line_level = 1'($urandom_range(0, 1));
      it.tx_byte    = 8'($urandom);
      it.start_req  = 1'($urandom_range(0, 1));
      it.mode       = it.start_req ? owm_pkg::ModeNone : 2'($urandom_range(0, 3));
      send_tick(it);
    end
  endtask

  // Runs one command from its start tick until the model is idle again.
  // The bus level follows what a slave would do: a presence pulse that starts
  // after pres_delay released ticks and lasts pres_len ticks, and the bits of
  // rx_plan on the sample ticks of a read. Every other tick carries a random
  // level and often a stray command request, which a busy master must ignore.
  // With break_at set, the run stops after that many ticks, drains, rewrites
  // one register mid-command and carries on.
  task automatic run_command(input logic [1:0] mode, input logic [7:0] tx,
                             input logic [7:0] rx_plan = 8'h00,
                             input int pres_delay = 0, input int pres_len = 1,
                             input int break_at = -1,
                             input owm_pkg::owm_reg_e break_reg = owm_pkg::REG_RESET_LOW,
                             input logic [9:0] break_val = '0);
    owm_pkg::owm_item_t it;
    int pres_k;
    int n;
    pres_k = 0;
    n = 0;
    it.line_level = 1'($urandom_range(0, 1));
    it.start_req  = 1'b1;
    it.mode       = mode;
    it.tx_byte    = tx;
    send_tick(it);
    while (cur_phase != owm_pkg::PH_IDLE) begin
      n++;
      if (n == break_at) begin
        drain_results();
        write_reg(break_reg, break_val);
        cfg_we_i <= 1'b0;
      end
      it.start_req = ($urandom_range(0, 3) == 0);
      it.mode      = 2'($urandom_range(0, 3));
      it.tx_byte   = 8'($urandom);
      case (cur_phase)
        owm_pkg::PH_PRES_WAIT, owm_pkg::PH_PRES_LOW: begin
          it.line_level = (pres_k < pres_delay) || (pres_k >= pres_delay + pres_len);
          pres_k++;
        end
        owm_pkg::PH_RD_SAMPLE: it.line_level = rx_plan[bit_pos];
        default:               it.line_level = 1'($urandom_range(0, 1));
      endcase
      send_tick(it);
    end
  endtask

  function automatic logic [7:0] short_len();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 40)) : 8'($urandom_range(0, 12));
  endfunction

  function automatic owm_pkg::owm_cfg_t random_timing();
    owm_pkg::owm_cfg_t c;
    c.reset_low_time    = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(13, 200))
                                                      : 10'($urandom_range(0, 12));
    c.reset_high_time   = short_len();
    c.presence_wait_max = short_len();
    c.presence_low_max  = short_len();
    c.write_one_low     = short_len();
    c.write_zero_low    = short_len();
    c.read_low          = short_len();
    c.read_tail         = short_len();
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Power-up timing: one of each command with the register values after reset.
  // Each command is cut short by a register write once its default segment has
  // run far enough, so the long default lengths do not dominate the run.
  task automatic test_default_timing();
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
    run_command(owm_pkg::ModeReset, 8'h00, 8'h00, 5, 10, 12, owm_pkg::REG_RESET_LOW, 10'd16);
    run_command(owm_pkg::ModeRead, 8'h00, 8'h3C, 0, 1, 20, owm_pkg::REG_RD_TAIL, 10'd3);
    run_command(owm_pkg::ModeWrite, 8'h00, 8'h00, 0, 1, 40, owm_pkg::REG_WR_ZERO, 10'd4);
    drain_results();
  endtask

  // Shortest timings, including zero lengths that must behave as one tick.
  // Covers a good presence pulse, a missing pulse, a pulse that stays low too
  // long, all-zero and all-one read bytes, writes of zero and one bits, and a
  // request with the unused mode.
  task automatic test_timing_floor();
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
    program_timing('{reset_low_time: 10'd1, reset_high_time: 8'd1, presence_wait_max: 8'd3,
                     presence_low_max: 8'd3, write_one_low: 8'd1, write_zero_low: 8'd0,
                     read_low: 8'd1, read_tail: 8'd0}, 2'b00);
    run_command(owm_pkg::ModeReset, 8'h00, 8'h00, 0, 1);
    run_command(owm_pkg::ModeReset, 8'h00, 8'h00, 1000, 1);
    run_command(owm_pkg::ModeReset, 8'h00, 8'h00, 1, 10);
    run_command(owm_pkg::ModeNone, 8'hFF);
    idle_ticks(3);
    run_command(owm_pkg::ModeWrite, 8'h00);
    run_command(owm_pkg::ModeWrite, 8'h80);
    run_command(owm_pkg::ModeRead, 8'h00, 8'hFF);
    run_command(owm_pkg::ModeRead, 8'h00, 8'h00);
    run_command(owm_pkg::ModeReset, 8'h00, 8'h00, 2, 2);
    drain_results();
  endtask

  // A register written while a command runs takes effect at once, also in the
  // segment that is under way.
  task automatic test_live_update();
    program_timing('{reset_low_time: 10'd40, reset_high_time: 8'd2, presence_wait_max: 8'd5,
                     presence_low_max: 8'd5, write_one_low: 8'd3, write_zero_low: 8'd6,
                     read_low: 8'd4, read_tail: 8'd12}, 2'b11);
    // Shorten the reset pulse below the ticks already spent in it.
    run_command(owm_pkg::ModeReset, 8'h00, 8'h00, 1, 2, 20, owm_pkg::REG_RESET_LOW, 10'd5);
    run_command(owm_pkg::ModeRead, 8'h00, 8'h96, 0, 1, 8, owm_pkg::REG_RD_TAIL, 10'd3);
    run_command(owm_pkg::ModeWrite, 8'h01, 8'h00, 0, 1, 70, owm_pkg::REG_WR_ZERO, 10'd2);
    drain_results();
  endtask

  // Mostly well-formed command sequences with random content and timings,
  // mixed with stray requests, presence failures and mid-command register
  // writes. Idling on both sides changes from command to command.
  task automatic test_random_traffic();
    int unsigned tick0;
    int unsigned ncmd;
    int unsigned wait_lim;
    int unsigned low_lim;
    int pres_delay;
    int pres_len;
    int break_at;
    logic [1:0] mode;
    tick0 = ticks_sent;
    ncmd  = 0;
    while (ticks_sent - tick0 < 200) begin
      if (ncmd % 3 == 0) begin
        drain_results();
        program_timing(random_timing(), 2'($urandom_range(0, 3)));
      end
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      idle_ticks($urandom_range(0, 3));

      case ($urandom_range(0, 9))
        0, 1, 2: mode = owm_pkg::ModeReset;
        3, 4, 5: mode = owm_pkg::ModeWrite;
        default: mode = owm_pkg::ModeRead;
      endcase

      wait_lim = (timing.presence_wait_max == 0) ? 1 : timing.presence_wait_max;
      low_lim  = (timing.presence_low_max == 0) ? 1 : timing.presence_low_max;
      case ($urandom_range(0, 5))
        0: begin  // no slave answers
          pres_delay = 1000;
          pres_len   = 1;
        end
        1: begin  // pulse held low past its limit
          pres_delay = $urandom_range(0, wait_lim - 1);
          pres_len   = low_lim + $urandom_range(0, 3);
        end
        default: begin
          pres_delay = $urandom_range(0, wait_lim);
          pres_len   = $urandom_range(1, low_lim);
        end
      endcase

      // Sparse write bytes keep the long fixed high time of one bits in check.
      break_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : -1;
      run_command(mode, 8'($urandom) & 8'($urandom) & 8'($urandom), 8'($urandom),
                  pres_delay, pres_len, break_at,
                  owm_pkg::owm_reg_e'($urandom_range(1, 7)), 10'(short_len()));

      // Now and then the source holds off until every result is back.
      if ($urandom_range(0, 3) == 0) drain_results();
      ncmd++;
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= owm_pkg::REG_RESET_LOW;
    cfg_wdata_i        <= '0;
    tick_ch.valid      <= 1'b0;
    tick_ch.line_level <= 1'b1;
    tick_ch.start_req  <= 1'b0;
    tick_ch.mode       <= owm_pkg::ModeReset;
    tick_ch.tx_byte    <= 8'h00;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_timing();
    test_timing_floor();
    test_live_update();
    test_random_traffic();

    drain_results();
    repeat (5) @(posedge clk_i);
    if (bus_results_due.size() != 0) begin
      $error("%0d predicted results never arrived", bus_results_due.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
